// ----- src/nss_pkg.sv -----
// ============================================================================
// nss_pkg
// shared types, codes and constants of the note step sequencer
// ============================================================================
package nss_pkg;

    localparam int MAX_STEPS   = 32;
    localparam int STEP_IDX_W  = $clog2(MAX_STEPS);

    localparam int ACTION_W    = 3;
    localparam int NOTE_W      = 7;
    localparam int PCT_W       = 7;
    localparam int RATCHET_W   = 4;
    localparam int COUNT_W     = 6;
    localparam int DIR_W       = 2;
    localparam int EVENT_W     = 2;
    localparam int RUN_W       = 2;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = ACTION_W;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = EVENT_W;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = COUNT_W;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PAUSE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd4;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_NOTE    = 2'd1;
    localparam logic [EVENT_W-1:0] EV_GATEOFF = 2'd2;
    localparam logic [EVENT_W-1:0] EV_SKIP    = 2'd3;

    // run states
    localparam logic [RUN_W-1:0] RUN_STOPPED = 2'd0;
    localparam logic [RUN_W-1:0] RUN_PLAYING = 2'd1;
    localparam logic [RUN_W-1:0] RUN_PAUSED  = 2'd2;

    // play directions
    localparam logic [DIR_W-1:0] DIR_FWD    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_BWD    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_PINGPONG = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RANDOM = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PLAY_DIR   = 1'd1;

    // reset values
    localparam logic [NOTE_W-1:0]    DEF_NOTE       = 7'd60;
    localparam logic [PCT_W-1:0]     DEF_GATE       = 7'd50;
    localparam logic [PCT_W-1:0]     FULL_PCT       = 7'd100;
    localparam logic [RATCHET_W-1:0] DEF_RATCHET    = 4'd1;
    localparam logic [COUNT_W-1:0]   DEF_STEP_COUNT = 6'd8;

    typedef struct packed {
        logic [NOTE_W-1:0]    note;
        logic [PCT_W-1:0]     gate;
        logic [PCT_W-1:0]     prob;
        logic [RATCHET_W-1:0] ratchet;
        logic                 rest;
    } step_entry_t;

    localparam step_entry_t DEF_ENTRY = '{
        note:    DEF_NOTE,
        gate:    DEF_GATE,
        prob:    FULL_PCT,
        ratchet: DEF_RATCHET,
        rest:    1'b0
    };

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

// ----- src/nss_step_store.sv -----
// ============================================================================
// nss_step_store
// step table in flip-flops, one write port, one read port
// ============================================================================
module nss_step_store
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [nss_pkg::STEP_IDX_W-1:0] wr_addr,
    input  nss_pkg::step_entry_t           wr_data,
    input  logic [nss_pkg::STEP_IDX_W-1:0] rd_addr,
    output nss_pkg::step_entry_t           rd_data
);
    import nss_pkg::*;

    step_entry_t entry_reg [MAX_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STEPS; i++)
            begin
                entry_reg[i] <= DEF_ENTRY;
            end
        end
        else if (wr_en)
        begin
            entry_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = entry_reg[rd_addr];

endmodule

// ----- src/nss_datapath.sv -----
// ============================================================================
// nss_datapath
// input register, sequencer state, step advance logic and result register
// ============================================================================
module nss_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  nss_pkg::ctrl_cmd_t              cmd,
    input  logic [nss_pkg::IN_TDATA_W-1:0]  in_tdata,
    input  logic [nss_pkg::IN_TUSER_W-1:0]  in_tuser,
    output logic [nss_pkg::OUT_TDATA_W-1:0] out_tdata,
    output logic [nss_pkg::OUT_TUSER_W-1:0] out_tuser,
    input  logic                            cfg_wr,
    input  logic [nss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nss_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import nss_pkg::*;

    typedef struct packed {
        logic [STEP_IDX_W-1:0] cur;
        logic                  bounce;
    } move_t;

    function automatic move_t move_on(
        input logic [STEP_IDX_W-1:0] cur,
        input logic [STEP_IDX_W-1:0] last,
        input logic [DIR_W-1:0]      dir,
        input logic                  bounce,
        input logic [STEP_IDX_W-1:0] rnd
    );
        move_t m;
        m.cur    = cur;
        m.bounce = bounce;
        case (dir)
            DIR_FWD:
            begin
                m.cur = (cur >= last) ? '0 : cur + 1'b1;
            end
            DIR_BWD:
            begin
                m.cur = (cur == '0 || cur > last) ? last : cur - 1'b1;
            end
            DIR_PINGPONG:
            begin
                if (last == '0)
                begin
                    m.cur    = '0;
                    m.bounce = 1'b1;
                end
                else
                begin
                    if (bounce)
                    begin
                        m.cur = (cur < last) ? cur + 1'b1 : last - 1'b1;
                    end
                    else
                    begin
                        m.cur = (cur > '0) ? cur - 1'b1 : STEP_IDX_W'(1);
                    end
                    if (m.cur >= last)
                    begin
                        m.bounce = 1'b0;
                    end
                    else if (m.cur == '0)
                    begin
                        m.bounce = 1'b1;
                    end
                end
            end
            default:
            begin
                m.cur = (rnd > last) ? last : rnd;
            end
        endcase
        return m;
    endfunction

    // captured item
    logic [IN_TDATA_W-1:0] in_data_reg;
    logic [IN_TUSER_W-1:0] in_user_reg;

    // sequencer state
    logic [STEP_IDX_W-1:0] cur_reg,    cur_next;
    logic [RUN_W-1:0]      run_reg,    run_next;
    logic                  bounce_reg, bounce_next;
    logic [RATCHET_W-1:0]  rc_reg,     rc_next;
    logic [COUNT_W-1:0]    count_reg,  count_next;
    logic [DIR_W-1:0]      dir_reg,    dir_next;

    // result payload
    logic [OUT_TDATA_W-1:0] res_data_reg, res_data_next;
    logic [OUT_TUSER_W-1:0] res_user_reg, res_user_next;

    // fields of the captured item
    logic [ACTION_W-1:0]   action;
    logic [STEP_IDX_W-1:0] step_index;
    logic [PCT_W-1:0]      roll;
    logic [STEP_IDX_W-1:0] rnd;
    step_entry_t           wr_entry;

    assign action         = in_user_reg;
    assign step_index     = in_data_reg[4:0];
    assign wr_entry.note    = in_data_reg[11:5];
    assign wr_entry.gate    = in_data_reg[18:12];
    assign wr_entry.prob    = in_data_reg[25:19];
    assign wr_entry.ratchet = in_data_reg[29:26];
    assign wr_entry.rest    = in_data_reg[30];
    assign roll           = in_data_reg[37:31];
    assign rnd            = in_data_reg[42:38];

    step_entry_t           cur_entry;
    logic                  store_wr;
    logic [STEP_IDX_W-1:0] last;
    logic [RATCHET_W-1:0]  rc_inc;
    logic [COUNT_W-1:0]    cfg_len;
    move_t                 mv;

    assign store_wr = cmd.execute && (action == ACT_WRITE);
    assign last     = STEP_IDX_W'(count_reg - 1'b1);
    assign rc_inc   = rc_reg + 1'b1;
    assign cfg_len  = cfg_data;
    assign mv       = move_on(cur_reg, last, dir_reg, bounce_reg, rnd);

    nss_step_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (store_wr),
        .wr_addr (step_index),
        .wr_data (wr_entry),
        .rd_addr (cur_reg),
        .rd_data (cur_entry)
    );

    always_comb
    begin
        logic [EVENT_W-1:0] ev;
        logic [NOTE_W-1:0]  note;
        logic [PCT_W-1:0]   gate;
        logic               adv;
        ev          = EV_NONE;
        note        = '0;
        gate        = '0;
        adv         = 1'b0;
        cur_next    = cur_reg;
        run_next    = run_reg;
        bounce_next = bounce_reg;
        rc_next     = rc_reg;
        count_next  = count_reg;
        dir_next    = dir_reg;

        if (cmd.execute)
        begin
            case (action)
                ACT_TICK:
                begin
                    if (run_reg == RUN_PLAYING)
                    begin
                        if (cur_entry.prob < FULL_PCT && roll > cur_entry.prob)
                        begin
                            ev  = EV_SKIP;
                            adv = 1'b1;
                        end
                        else if (cur_entry.rest)
                        begin
                            ev  = EV_GATEOFF;
                            adv = 1'b1;
                        end
                        else
                        begin
                            ev   = EV_NOTE;
                            note = cur_entry.note;
                            gate = cur_entry.gate;
                            if (cur_entry.ratchet > DEF_RATCHET)
                            begin
                                if (rc_inc >= cur_entry.ratchet)
                                begin
                                    rc_next = '0;
                                    adv     = 1'b1;
                                end
                                else
                                begin
                                    rc_next = rc_inc;
                                end
                            end
                            else
                            begin
                                adv = 1'b1;
                            end
                        end
                    end
                    if (adv)
                    begin
                        cur_next    = mv.cur;
                        bounce_next = mv.bounce;
                    end
                end
                ACT_START:
                begin
                    cur_next    = '0;
                    run_next    = RUN_PLAYING;
                    bounce_next = 1'b1;
                end
                ACT_STOP:
                begin
                    cur_next = '0;
                    run_next = RUN_STOPPED;
                    ev       = EV_GATEOFF;
                end
                ACT_PAUSE:
                begin
                    if (run_reg == RUN_PLAYING)
                    begin
                        run_next = RUN_PAUSED;
                        ev       = EV_GATEOFF;
                    end
                    else if (run_reg == RUN_PAUSED)
                    begin
                        run_next = RUN_PLAYING;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_STEP_COUNT:
                begin
                    if (cfg_len >= COUNT_W'(1) && cfg_len <= COUNT_W'(MAX_STEPS))
                    begin
                        count_next = cfg_len;
                        if (COUNT_W'(cur_reg) >= cfg_len)
                        begin
                            cur_next = '0;
                        end
                    end
                end
                default:
                begin
                    dir_next    = cfg_data[DIR_W-1:0];
                    bounce_next = 1'b1;
                end
            endcase
        end

        res_user_next = ev;
        res_data_next = {7'd0, (run_next == RUN_PLAYING), cur_next, cur_reg, gate, note};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_data_reg <= in_tdata;
            in_user_reg <= in_tuser;
        end
        if (cmd.execute)
        begin
            res_data_reg <= res_data_next;
            res_user_reg <= res_user_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            run_reg    <= RUN_STOPPED;
            bounce_reg <= 1'b1;
            rc_reg     <= '0;
            count_reg  <= DEF_STEP_COUNT;
            dir_reg    <= DIR_FWD;
        end
        else
        begin
            cur_reg    <= cur_next;
            run_reg    <= run_next;
            bounce_reg <= bounce_next;
            rc_reg     <= rc_next;
            count_reg  <= count_next;
            dir_reg    <= dir_next;
        end
    end

    assign out_tdata = res_data_reg;
    assign out_tuser = res_user_reg;

endmodule

// ----- src/nss_ctrl.sv -----
// ============================================================================
// nss_ctrl
// controller: capture, execute and output handshake
// ============================================================================
module nss_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output nss_pkg::ctrl_cmd_t cmd
);
    import nss_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.capture    = 1'b0;
        cmd.execute    = 1'b0;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // result register must be free or emptying this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- src/note_step_sequencer_unit.sv -----
// ============================================================================
// note_step_sequencer_unit
// music step sequencer with a 32 entry step table and play/pause/stop control
// ============================================================================
// usage
//   s_axis carries one action per item: tick, start, stop, pause/resume or
//   step write, selected by tuser; tdata holds the step contents to write
//   and the random roll and random step used by a tick.
//   m_axis returns exactly one result item per input item: the event kind in
//   tuser, note, gate length, handled step, next step and play flag in tdata.
//   cfg writes step_count (index 0) and play_direction (index 1); write only
//   while no item is in flight. cfg_ready is always high.
// timing
//   an item is captured in the idle state and executed from the exec state,
//   so the block takes no new item until the last one has executed; the result
//   appears on m_axis the cycle after execution.
//   the single result register decouples the sides: a new item is taken
//   while a result still waits, and execution holds when the receiver stalls.
// reset
//   rst_n clears the run state to stopped, step 0, bounce up, length 8,
//   forward direction, and loads every step with note 60, gate 50,
//   probability 100, ratchet 1; the block is ready right after reset.
// ============================================================================
module note_step_sequencer_unit
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // step_index[4:0], new_note[11:5], new_gate_length[18:12],
    // new_probability[25:19], new_ratchet[29:26], new_rest[30],
    // random_roll[37:31], random_step[42:38], zero fill [47:43]
    input  logic [nss_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // action[2:0]
    input  logic [nss_pkg::IN_TUSER_W-1:0]  s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // note_out[6:0], gate_length_out[13:7], played_step[18:14],
    // next_step[23:19], is_playing[24], zero fill [31:25]
    output logic [nss_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // event_res[1:0]
    output logic [nss_pkg::OUT_TUSER_W-1:0] m_axis_tuser,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nss_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import nss_pkg::*;

    ctrl_cmd_t cmd;
    logic      cfg_wr;

    // configuration must only be written while idle, so it never races an item; the block does not enforce this
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    nss_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    nss_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_tdata  (s_axis_tdata),
        .in_tuser  (s_axis_tuser),
        .out_tdata (m_axis_tdata),
        .out_tuser (m_axis_tuser),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
